// ----- rtl/rrq_pkg.sv -----
// rrq_pkg: action and status codes for the round-robin run queue
// no dependencies
package rrq_pkg;
  localparam int ID_W = 5;
  localparam int ID_SPACE = 32;

  typedef enum logic [2:0] {
    ACT_WAKE     = 3'd0,
    ACT_SUSPEND  = 3'd1,
    ACT_SPAWN    = 3'd2,
    ACT_START    = 3'd3,
    ACT_KILL     = 3'd4,
    ACT_SCHEDULE = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_QUEUED      = 3'd1,
    ST_NOT_QUEUED  = 3'd2,
    ST_NO_FREE     = 3'd3,
    ST_NOT_WAITING = 3'd4,
    ST_EMPTY       = 3'd5
  } status_t;
endpackage

// ----- rtl/rrq_ram.sv -----
// rrq_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
module rrq_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/round_robin_run_queue.sv -----
// round_robin_run_queue: top level, sequencer around the run order ram
// depends on rrq_pkg and rrq_ram
//
// usage: drive in_action and in_task_id with start high while busy is low;
// the word is taken at that edge and busy rises. when the operation ends,
// out_strobe is high for one cycle with status, result id and the current
// task; busy falls in the same cycle so a new word may follow at once.
// the receiver cannot stall; every result is taken in its strobe cycle.
// path from the accepting edge to the strobe: schedule runs the schedule,
// current read and done states; a start of a task not awaiting start, or
// an unknown action, goes straight to the current read; spawn tests one id
// flag a cycle; wake and start search the queue, then append; suspend and
// kill search, then shift the later slots down, and kill then schedules.
// the one read port of the run order ram shapes the walks: the search walk
// reads a slot, then compares it; the shift walk reads a slot, then writes
// it one slot down. reset clears the queue count, the mark and the id flags
// at once; the ram needs no clearing, only slots below the count are read.
module round_robin_run_queue #(
  parameter int MAX_TASKS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_action,
  input  logic [rrq_pkg::ID_W-1:0] in_task_id,
  output logic                     out_strobe,
  output logic [2:0]               out_status,
  output logic [rrq_pkg::ID_W-1:0] out_result_id,
  output logic                     out_result_valid,
  output logic [rrq_pkg::ID_W-1:0] out_current_id,
  output logic                     out_current_valid
);
  import rrq_pkg::*;

  // only ids below min(MAX_TASKS, 32) can ever be spawned or started
  localparam int LIM = (MAX_TASKS < ID_SPACE) ? MAX_TASKS : ID_SPACE;
  localparam int LW = $clog2(LIM);
  localparam int TW = $clog2(LIM + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCHW, S_SHIFT, S_SHIFTW, S_SPAWN,
    S_SCHED, S_CUR, S_CURW, S_DONE
  } state_t;

  state_t             state_r;
  logic [2:0]         act_r;
  logic [ID_W-1:0]    id_r;
  logic [ID_W:0]      cnt_r;
  logic [ID_W-1:0]    cur_r;
  logic               pres_r;
  logic [ID_W:0]      idx_r;
  logic [TW-1:0]      tidx_r;
  logic [ID_W-1:0]    slot_r;
  logic [2:0]         stat_r;
  logic [ID_W-1:0]    rid_r;
  logic               rval_r;
  logic [LIM-1:0]     used_r, await_r;

  logic               we;
  logic [ID_W-1:0]    waddr, wdata, raddr, rdata;

  rrq_ram #(.WIDTH(ID_W), .DEPTH(ID_SPACE)) u_order (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign busy = (state_r != S_IDLE);

  // ram port control, driven from the walk index, the queue count and the current slot
  always_comb begin
    we = 1'b0;
    waddr = idx_r[ID_W-1:0];
    wdata = rdata;
    raddr = idx_r[ID_W-1:0];
    unique case (state_r)
      S_SHIFTW: begin
        we = 1'b1;
        waddr = ID_W'(idx_r - 1'b1);
      end
      S_IDLE: begin
        we = 1'b0;
      end
      default: we = 1'b0;
    endcase
    if (state_r == S_SCHED && (act_r == ACT_WAKE || act_r == ACT_START)
        && stat_r == ST_OK) begin
      we = 1'b1;
      waddr = cnt_r[ID_W-1:0];
      wdata = id_r;
    end
    // keep the current slot on the read port until the result is registered
    if (state_r == S_CUR || state_r == S_CURW) raddr = cur_r;
  end

  logic fix_taken;
  logic [ID_W-1:0] nslot;
  always_comb begin
    fix_taken = (state_r == S_SRCHW) && (rdata == id_r);
    nslot = pres_r ? ID_W'(cur_r + 1'b1) : ID_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      cur_r <= '0;
      pres_r <= 1'b0;
      used_r <= '0;
      await_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start) begin
          act_r <= in_action;
          id_r <= in_task_id;
          idx_r <= '0;
          tidx_r <= '0;
          stat_r <= ST_OK;
          rid_r <= '0;
          rval_r <= 1'b0;
          unique case (in_action)
            ACT_WAKE, ACT_SUSPEND, ACT_KILL: state_r <= S_SRCH;
            ACT_SPAWN: state_r <= S_SPAWN;
            ACT_START: begin
              if (32'(in_task_id) >= MAX_TASKS ||
                  !await_r[in_task_id[LW-1:0]]) begin
                stat_r <= ST_NOT_WAITING;
                state_r <= S_CUR;
              end else begin
                await_r[in_task_id[LW-1:0]] <= 1'b0;
                state_r <= S_SRCH;
              end
            end
            ACT_SCHEDULE: state_r <= S_SCHED;
            default: state_r <= S_CUR;
          endcase
        end
        S_SPAWN: begin
          if (32'(tidx_r) >= LIM) begin
            stat_r <= ST_NO_FREE;
            state_r <= S_CUR;
          end else if (!used_r[tidx_r[LW-1:0]]) begin
            used_r[tidx_r[LW-1:0]] <= 1'b1;
            await_r[tidx_r[LW-1:0]] <= 1'b1;
            rid_r <= ID_W'(tidx_r);
            rval_r <= 1'b1;
            state_r <= S_CUR;
          end else tidx_r <= TW'(tidx_r + 1'b1);
        end
        // search: read slot idx, compare next cycle
        S_SRCH: begin
          if (idx_r >= cnt_r) begin
            if (act_r == ACT_WAKE || act_r == ACT_START) state_r <= S_SCHED;
            else begin
              stat_r <= ST_NOT_QUEUED;
              state_r <= (act_r == ACT_KILL) ? S_SCHED : S_CUR;
            end
          end else state_r <= S_SRCHW;
        end
        S_SRCHW: begin
          if (fix_taken) begin
            if (act_r == ACT_WAKE || act_r == ACT_START) begin
              stat_r <= ST_QUEUED;
              state_r <= S_CUR;
            end else begin
              slot_r <= idx_r[ID_W-1:0];
              idx_r <= idx_r + 1'b1;
              state_r <= S_SHIFT;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= S_SRCH;
          end
        end
        // shift: move slot idx down to idx-1
        S_SHIFT: begin
          if (idx_r >= cnt_r) begin
            cnt_r <= cnt_r - 1'b1;
            if (cnt_r == 1) begin
              pres_r <= 1'b0;
              cur_r <= '0;
            end else if (pres_r) begin
              if (cur_r > slot_r) cur_r <= cur_r - 1'b1;
              else if (cur_r == slot_r)
                cur_r <= (slot_r == 0) ? ID_W'(cnt_r - 2'd2) : slot_r - 1'b1;
            end
            state_r <= (act_r == ACT_KILL) ? S_SCHED : S_CUR;
          end else state_r <= S_SHIFTW;
        end
        S_SHIFTW: begin
          idx_r <= idx_r + 1'b1;
          state_r <= S_SHIFT;
        end
        S_SCHED: begin
          if (act_r == ACT_WAKE || act_r == ACT_START) begin
            if (cnt_r == 0) begin
              cur_r <= '0;
              pres_r <= 1'b1;
            end
            cnt_r <= cnt_r + 1'b1;
          end else if (cnt_r == 0) begin
            if (act_r == ACT_SCHEDULE || stat_r == ST_OK) stat_r <= ST_EMPTY;
          end else begin
            cur_r <= ({1'b0, nslot} >= cnt_r) ? '0 : nslot;
            pres_r <= 1'b1;
            rval_r <= 1'b1;
            rid_r <= '1;
          end
          state_r <= S_CUR;
        end
        S_CUR: state_r <= S_CURW;
        S_CURW: begin
          if (rid_r == '1 && rval_r && act_r != ACT_SPAWN) rid_r <= rdata;
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_strobe <= 1'b1;
          out_status <= stat_r;
          out_result_id <= rid_r;
          out_result_valid <= rval_r;
          out_current_valid <= pres_r && ({1'b0, cur_r} < cnt_r);
          out_current_id <= (pres_r && ({1'b0, cur_r} < cnt_r)) ? rdata : '0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- dv/round_robin_run_queue_test.sv -----
// round_robin_run_queue_test: self-checking bench for the round-robin run queue
// holds its own scheduler predictor and drives directed, id exhaustion, then random words
// depends on rrq_pkg and round_robin_run_queue
`timescale 1ns / 1ps

module round_robin_run_queue_test;
  import rrq_pkg::*;

  localparam int TASKS = 32;

  typedef struct packed {
    logic [2:0]      status;
    logic [ID_W-1:0] result_id;
    logic            result_valid;
    logic [ID_W-1:0] current_id;
    logic            current_valid;
  } sched_reply_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  logic [2:0]      in_action = '0;
  logic [ID_W-1:0] in_task_id = '0;
  logic            out_strobe;
  logic [2:0]      out_status;
  logic [ID_W-1:0] out_result_id;
  logic            out_result_valid;
  logic [ID_W-1:0] out_current_id;
  logic            out_current_valid;

  // predictor state
  logic [ID_W-1:0] order_q [ID_SPACE];
  int              order_len;
  int              mark_slot;
  logic            mark_present;
  logic [TASKS-1:0] id_taken;
  logic [TASKS-1:0] id_waiting;

  sched_reply_t    pending_replies [$];
  int              fail_count = 0;
  bit              calm = 1'b0;

  round_robin_run_queue #(.MAX_TASKS(TASKS)) u_dut (
    .clk, .rst_n, .start, .busy, .in_action, .in_task_id, .out_strobe, .out_status,
    .out_result_id, .out_result_valid, .out_current_id, .out_current_valid
  );

  always #10 clk = ~clk;

  function automatic int slot_of(logic [ID_W-1:0] id);
    for (int i = 0; i < order_len; i++)
      if (order_q[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [2:0] enqueue_task(logic [ID_W-1:0] id);
    if (slot_of(id) >= 0 || order_len >= ID_SPACE) return ST_QUEUED;
    order_q[order_len] = id;
    if (order_len == 0) begin
      mark_slot = 0;
      mark_present = 1'b1;
    end
    order_len++;
    return ST_OK;
  endfunction

  function automatic logic [2:0] dequeue_task(logic [ID_W-1:0] id);
    int s;
    s = slot_of(id);
    if (s < 0) return ST_NOT_QUEUED;
    for (int i = s; i + 1 < order_len; i++) order_q[i] = order_q[i + 1];
    order_len--;
    if (order_len == 0) begin
      mark_present = 1'b0;
      mark_slot = 0;
    end else if (mark_present) begin
      if (mark_slot > s) mark_slot--;
      // current removed: back to predecessor, head wraps to tail
      else if (mark_slot == s) mark_slot = (s == 0) ? order_len - 1 : s - 1;
    end
    return ST_OK;
  endfunction

  function automatic bit advance_mark(output logic [ID_W-1:0] id);
    int slot;
    id = '0;
    if (order_len == 0) return 1'b0;
    slot = mark_present ? mark_slot + 1 : 1;
    if (slot >= order_len) slot = 0;
    mark_slot = slot;
    mark_present = 1'b1;
    id = order_q[slot];
    return 1'b1;
  endfunction

  function automatic sched_reply_t predict_reply(logic [2:0] act, logic [ID_W-1:0] id);
    sched_reply_t r;
    r = '0;
    case (act)
      ACT_WAKE: begin
        r.status = enqueue_task(id);
      end
      ACT_SUSPEND: begin
        r.status = dequeue_task(id);
      end
      ACT_SPAWN: begin
        r.status = ST_NO_FREE;
        for (int i = 0; i < TASKS; i++) begin
          if (!id_taken[i]) begin
            id_taken[i] = 1'b1;
            id_waiting[i] = 1'b1;
            r.result_id = i[ID_W-1:0];
            r.result_valid = 1'b1;
            r.status = ST_OK;
            break;
          end
        end
      end
      ACT_START: begin
        if (id >= TASKS || !id_waiting[id]) begin
          r.status = ST_NOT_WAITING;
        end else begin
          id_waiting[id] = 1'b0;
          r.status = enqueue_task(id);
        end
      end
      ACT_KILL: begin
        r.status = dequeue_task(id);
        r.result_valid = advance_mark(r.result_id);
        if (!r.result_valid && r.status == ST_OK) r.status = ST_EMPTY;
      end
      ACT_SCHEDULE: begin
        r.result_valid = advance_mark(r.result_id);
        if (!r.result_valid) r.status = ST_EMPTY;
      end
      default: ;
    endcase
    if (mark_present && mark_slot < order_len) begin
      r.current_id = order_q[mark_slot];
      r.current_valid = 1'b1;
    end
    return r;
  endfunction

  // one word: random gap, wait for not busy, hold start for the accepting edge
  task automatic issue_word(logic [2:0] act, logic [ID_W-1:0] id);
    if (!calm && $urandom_range(99) < 8) repeat ($urandom_range(1, 6)) @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1'b1;
    in_action <= act;
    in_task_id <= id;
    @(posedge clk);
    pending_replies.push_back(predict_reply(act, id));
    @(negedge clk);
    start <= 1'b0;
    in_action <= 3'($urandom);
    in_task_id <= ID_W'($urandom);
  endtask

  always @(posedge clk) begin
    sched_reply_t want;
    if (rst_n && out_strobe) begin
      if (pending_replies.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status); fail_count++;
        end
        if (out_result_id !== want.result_id) begin
          $error("result_id: expected %0d, got %0d", want.result_id, out_result_id);
          fail_count++;
        end
        if (out_result_valid !== want.result_valid) begin
          $error("result_valid: expected %0d, got %0d", want.result_valid,
                 out_result_valid);
          fail_count++;
        end
        if (out_current_id !== want.current_id) begin
          $error("current_id: expected %0d, got %0d", want.current_id, out_current_id);
          fail_count++;
        end
        if (out_current_valid !== want.current_valid) begin
          $error("current_valid: expected %0d, got %0d", want.current_valid,
                 out_current_valid);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    issue_word(ACT_SCHEDULE, 0);
    issue_word(ACT_KILL, 31);
    issue_word(ACT_SUSPEND, 7);
    issue_word(ACT_START, 0);
    issue_word(ACT_SPAWN, 31);
    issue_word(ACT_SPAWN, 0);
    issue_word(ACT_START, 0);
    issue_word(ACT_START, 0);
    issue_word(ACT_WAKE, 0);
    issue_word(ACT_SCHEDULE, 0);
    issue_word(ACT_WAKE, 31);
    issue_word(ACT_WAKE, 5);
    issue_word(ACT_SPAWN, 0);
    issue_word(ACT_WAKE, 1);
    issue_word(ACT_START, 1);
    issue_word(ACT_SCHEDULE, 0);
    issue_word(ACT_SUSPEND, 31);
    issue_word(ACT_SUSPEND, 0);
    issue_word(ACT_KILL, 1);
    issue_word(3'd6, 5'd21);
    issue_word(3'd7, 5'd10);
    issue_word(ACT_KILL, 5);
    issue_word(ACT_KILL, 5);
  endtask

  // spawn every id, then one more for the no-free-id case, then start every third id
  task automatic test_id_exhaustion();
    for (int i = 0; i <= TASKS; i++) issue_word(ACT_SPAWN, ID_W'($urandom));
    for (int i = 0; i < TASKS; i += 3) issue_word(ACT_START, ID_W'(i));
  endtask

  task automatic test_random_mix(int words);
    int pick;
    logic [2:0] act;
    for (int n = 0; n < words; n++) begin
      calm = (n >= words / 3 && n < words / 2);
      pick = $urandom_range(99);
      if (pick < 30) act = ACT_WAKE;
      else if (pick < 50) act = ACT_SUSPEND;
      else if (pick < 55) act = ACT_SPAWN;
      else if (pick < 65) act = ACT_START;
      else if (pick < 75) act = ACT_KILL;
      else if (pick < 97) act = ACT_SCHEDULE;
      else act = 3'($urandom_range(6, 7));
      // bias ids to queued tasks so removals usually hit
      if (order_len > 0 && $urandom_range(1) == 1 && (act == ACT_SUSPEND || act == ACT_KILL))
        issue_word(act, order_q[$urandom_range(order_len - 1)]);
      else
        issue_word(act, ID_W'($urandom));
    end
    calm = 1'b0;
  endtask

  initial begin
    order_len = 0;
    mark_slot = 0;
    mark_present = 1'b0;
    id_taken = '0;
    id_waiting = '0;
    foreach (order_q[i]) order_q[i] = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_id_exhaustion();
    test_random_mix(1370);
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0 && pending_replies.size() == 0) $display("round_robin_run_queue_test: clean");
    else $display("round_robin_run_queue_test: errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("round_robin_run_queue_test: errors");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/rrq_pkg.sv
rtl/rrq_ram.sv
rtl/round_robin_run_queue.sv
dv/round_robin_run_queue_test.sv
